@@ hdl/bust_pkg.sv @@
package bust_pkg;

  // Table size, the widths that follow from it, and the fixed position and value widths.
  localparam int unsigned CAPACITY = 32;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned POS_W    = 5;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_REMOVE = 2'd1,
    FN_LOOKUP = 2'd2,
    FN_READ   = 2'd3
  } bust_func_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_PRESENT = 3'd1,
    ST_FULL    = 3'd2,
    ST_ABSENT  = 3'd3,
    ST_RANGE   = 3'd4
  } bust_status_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_CMP,
    PH_UPD
  } bust_phase_e;

  typedef struct packed {
    logic [1:0]       func;
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] position;
  } bust_in_t;

  typedef struct packed {
    logic [2:0]       status;
    logic             found;
    logic [5:0]       count;
    logic [VAL_W-1:0] read_value;
  } bust_out_t;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic             cmp;
    logic             remove;
    logic             insert;
    logic [CNT_W-1:0] count;
    logic [VAL_W-1:0] key;
    logic [POS_W-1:0] pos;
  } bust_ctrl_t;

  // Read word travelling along the chain.
  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] data;
  } bust_rd_t;

endpackage

@@ hdl/bust_cell.sv @@
module bust_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [bust_pkg::IDX_W-1:0]   index_i,
  input  bust_pkg::bust_ctrl_t         ctrl_i,
  input  logic [bust_pkg::VAL_W-1:0]   next_entry_i,
  output logic [bust_pkg::VAL_W-1:0]   entry_o,
  input  logic                         seen_i,
  output logic                         seen_o,
  input  bust_pkg::bust_rd_t           rd_i,
  output bust_pkg::bust_rd_t           rd_o
);

  logic [bust_pkg::VAL_W-1:0] entry_q, entry_d;
  logic                       match_q;
  logic                       valid;
  logic                       at_tail;
  logic                       rd_sel;

  // The cell holds a live entry when its place lies below the count.
  assign valid   = bust_pkg::CNT_W'(index_i) < ctrl_i.count;
  assign at_tail = bust_pkg::CNT_W'(index_i) == ctrl_i.count;
  assign entry_o = entry_q;

  // Compare phase: register whether this entry equals the key.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctrl_i.cmp) begin
      match_q <= valid && (entry_q == ctrl_i.key);
    end
  end

  // A match at this place or any lower one is passed up the chain.
  assign seen_o = seen_i | match_q;

  // Removal pulls the upper neighbour down; insertion fills the first free place.
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.remove && seen_o) begin
      entry_d = next_entry_i;
    end else if (ctrl_i.insert && at_tail) begin
      entry_d = ctrl_i.key;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  // Read: the cell at the requested place drops its word onto the chain.
  assign rd_sel    = valid &&
                     (bust_pkg::CMP_W'(index_i) == bust_pkg::CMP_W'(ctrl_i.pos));
  assign rd_o.hit  = rd_i.hit | rd_sel;
  assign rd_o.data = rd_i.data | (rd_sel ? entry_q : '0);

endmodule

@@ hdl/bounded_unique_set_table.sv @@
// Each word passes through a compare phase, which checks the key against every
// cell, and an update phase, which updates the row and registers the result. The
// result strobe is registered from the update phase, and a new word may be started
// in the update cycle of the last word. The receiver cannot stall.
// Reset empties the table (count zero); stored entries are not cleared.
module bounded_unique_set_table (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  bust_pkg::bust_in_t   req_i,
  output logic                 res_valid_o,
  output bust_pkg::bust_out_t  res_o
);

  localparam int unsigned N = bust_pkg::CAPACITY;

  bust_pkg::bust_phase_e          phase_q, phase_d;
  bust_pkg::bust_in_t             req_q;
  logic [bust_pkg::CNT_W-1:0]     count_q, count_d;
  bust_pkg::bust_out_t            res_q, res_d;
  logic                           res_valid_q;
  logic                           accept;
  logic                           upd;
  logic                           found;
  logic                           full;
  bust_pkg::bust_ctrl_t           ctrl;

  logic [bust_pkg::VAL_W-1:0]     entry [N];
  logic [N:0]                     seen;
  bust_pkg::bust_rd_t             rd [N+1];

  assign busy   = (phase_q == bust_pkg::PH_CMP);
  assign accept = start && !busy;
  assign upd    = (phase_q == bust_pkg::PH_UPD);
  assign found  = seen[N];
  assign full   = (count_q >= bust_pkg::CNT_W'(N));

  // Phase sequencing.
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      bust_pkg::PH_IDLE: if (accept) phase_d = bust_pkg::PH_CMP;
      bust_pkg::PH_CMP:  phase_d = bust_pkg::PH_UPD;
      bust_pkg::PH_UPD:  phase_d = accept ? bust_pkg::PH_CMP : bust_pkg::PH_IDLE;
      default:           phase_d = bust_pkg::PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= bust_pkg::PH_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  // Request word register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
  end

  // Broadcast control for the cell row.
  always_comb begin
    ctrl.cmp    = (phase_q == bust_pkg::PH_CMP);
    ctrl.remove = upd && (req_q.func == bust_pkg::FN_REMOVE) && found;
    ctrl.insert = upd && (req_q.func == bust_pkg::FN_INSERT) && !found && !full;
    ctrl.count  = count_q;
    ctrl.key    = req_q.value;
    ctrl.pos    = req_q.position;
  end

  // The row of cells.
  assign seen[0]     = 1'b0;
  assign rd[0].hit   = 1'b0;
  assign rd[0].data  = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [bust_pkg::VAL_W-1:0] next_entry;
    if (i == N - 1) begin : g_last
      assign next_entry = entry[i];
    end else begin : g_mid
      assign next_entry = entry[i+1];
    end

    bust_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .index_i      (bust_pkg::IDX_W'(i)),
      .ctrl_i       (ctrl),
      .next_entry_i (next_entry),
      .entry_o      (entry[i]),
      .seen_i       (seen[i]),
      .seen_o       (seen[i+1]),
      .rd_i         (rd[i]),
      .rd_o         (rd[i+1])
    );
  end

  // Count update and result formation in the update cycle.
  always_comb begin
    count_d = count_q;
    if (ctrl.insert) begin
      count_d = count_q + bust_pkg::CNT_W'(1);
    end else if (ctrl.remove) begin
      count_d = count_q - bust_pkg::CNT_W'(1);
    end

    res_d.status     = bust_pkg::ST_OK;
    res_d.found      = 1'b0;
    res_d.read_value = '0;
    unique case (bust_pkg::bust_func_e'(req_q.func))
      bust_pkg::FN_INSERT: begin
        res_d.found = found;
        if (found) begin
          res_d.status = bust_pkg::ST_PRESENT;
        end else if (full) begin
          res_d.status = bust_pkg::ST_FULL;
        end
      end
      bust_pkg::FN_REMOVE, bust_pkg::FN_LOOKUP: begin
        res_d.found = found;
        if (!found) begin
          res_d.status = bust_pkg::ST_ABSENT;
        end
      end
      bust_pkg::FN_READ: begin
        if (rd[N].hit) begin
          res_d.read_value = rd[N].data;
        end else begin
          res_d.status = bust_pkg::ST_RANGE;
        end
      end
      default: res_d.status = bust_pkg::ST_OK;
    endcase
    res_d.count = 6'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      res_valid_q <= upd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
